// File: rtl/substring_first_match_search_macros.svh
// assertion macros shared by the checker
`ifndef SUBSTRING_FIRST_MATCH_SEARCH_MACROS_SVH
`define SUBSTRING_FIRST_MATCH_SEARCH_MACROS_SVH

// same-cycle implication, clocked and reset-qualified
`define SFMS_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication
`define SFMS_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

// File: rtl/sfms_pkg.sv
`default_nettype none

package sfms_pkg;

  localparam int MaxTextLen = 4096;
  localparam int MaxPatLen  = 32;
  localparam int CharW      = 8;
  localparam int PosW       = 12;
  localparam int LenW       = $clog2(MaxPatLen + 1);
  localparam int IdxW       = $clog2(MaxTextLen + 1);

  localparam logic ReqPattern = 1'b0;
  localparam logic ReqText    = 1'b1;

  typedef logic [CharW-1:0] char_t;
  typedef logic [PosW-1:0]  pos_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [IdxW-1:0]  idx_t;

  typedef struct packed {
    logic win_shift;
    logic pat_shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/sfms_if.sv
`default_nettype none

interface sfms_in_if;
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [7:0]            ch;
  logic                  last;

  modport source (output valid, output req_type, output ch, output last, input ready);
  modport sink   (input valid, input req_type, input ch, input last, output ready);
endinterface

interface sfms_out_if;
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [11:0]           match_pos;
  logic                  pattern_overflow;
  logic                  text_overflow;

  modport source (output valid, output found, output match_pos, output pattern_overflow,
                  output text_overflow, input ready);
  modport sink   (input valid, input found, input match_pos, input pattern_overflow,
                  input text_overflow, output ready);
endinterface

interface sfms_cfg_if;
  logic                  valid;
  logic                  ready;
  logic [11:0]           start_pos;

  modport source (output valid, output start_pos, input ready);
  modport sink   (input valid, input start_pos, output ready);
endinterface

`default_nettype wire

// File: rtl/sfms_cell.sv
`default_nettype none

module sfms_cell (
  input  logic                clk_i,
  input  sfms_pkg::cell_ctrl_t ctrl_i,
  input  sfms_pkg::char_t     win_i,
  input  sfms_pkg::char_t     pat_i,
  output sfms_pkg::char_t     win_o,
  output sfms_pkg::char_t     pat_o,
  output logic                hit_o
);
  import sfms_pkg::*;

  char_t win_q;
  char_t pat_q;

  // window and reversed pattern both shift one cell per transfer
  always_ff @(posedge clk_i) begin
    if (ctrl_i.win_shift) begin
      win_q <= win_i;
    end
    if (ctrl_i.pat_shift) begin
      pat_q <= pat_i;
    end
  end

  // compare the character entering this cell against the pattern held here
  assign hit_o = (win_i == pat_q);
  assign win_o = win_q;
  assign pat_o = pat_q;

endmodule

`default_nettype wire

// File: rtl/substring_first_match_search.sv
// channel  | dir | payload                                           | transfer
// ---------+-----+---------------------------------------------------+-----------------
// in_i     | in  | req_type, ch, last                                | valid && ready
// out_o    | out | found, match_pos, pattern_overflow, text_overflow | valid && ready
// cfg_i    | in  | start_pos                                         | valid && ready
//
// one item per cycle unless stalled; a result shows the cycle after the last text char
// each char moves one step down a row of 32 cells; all cells compare in parallel
// in_i.ready drops only while a result sits in the output register and out_o.ready is low
// cfg_i.ready is always high; rst_ni clears control state, no clearing pass
`default_nettype none

module substring_first_match_search (
  input  logic            clk_i,
  input  logic            rst_ni,
  sfms_in_if.sink         in_i,
  sfms_out_if.source      out_o,
  sfms_cfg_if.sink        cfg_i
);
  import sfms_pkg::*;

  logic       in_fire;
  logic       is_text;
  logic       pat_fire;
  logic       txt_fire;
  logic       txt_live;
  cell_ctrl_t ctrl;

  pos_t   start_q;
  len_t   pat_len_q, pat_len_d, pat_base;
  logic   pat_closed_q, pat_closed_d;
  logic   pat_long_q, pat_long_d;
  idx_t   idx_q, idx_d;
  logic   seen_q, seen_d;
  pos_t   first_q, first_d;
  logic   txt_long_q, txt_long_d;

  logic   ovalid_q;
  logic   found_q;
  pos_t   mpos_q;
  logic   povf_q;
  logic   tovf_q;

  char_t  win_row [MaxPatLen];
  char_t  pat_row [MaxPatLen];
  logic [MaxPatLen-1:0] hit;
  logic [MaxPatLen-1:0] care;

  idx_t   idx_inc;
  idx_t   diff;
  logic   pat_ok;
  logic   win_eq;
  logic   match;
  logic   seen_now;
  pos_t   first_now;

  assign in_i.ready  = !ovalid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign is_text     = (in_i.req_type == ReqText);
  assign pat_fire    = in_fire && !is_text;
  assign txt_fire    = in_fire && is_text;
  assign txt_live    = txt_fire && !idx_q[IdxW-1];

  // a closed pattern restarts at length zero on its next char
  assign pat_base       = pat_closed_q ? '0 : pat_len_q;
  assign ctrl.pat_shift = pat_fire && (pat_base < len_t'(MaxPatLen));
  assign ctrl.win_shift = txt_live;

  for (genvar k = 0; k < MaxPatLen; k++) begin : g_cell
    char_t win_in;
    char_t pat_in;
    if (k == 0) begin : g_head
      assign win_in = in_i.ch;
      assign pat_in = in_i.ch;
    end else begin : g_body
      assign win_in = win_row[k-1];
      assign pat_in = pat_row[k-1];
    end
    assign care[k] = (pat_len_q > len_t'(k));
    sfms_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .win_i  (win_in),
      .pat_i  (pat_in),
      .win_o  (win_row[k]),
      .pat_o  (pat_row[k]),
      .hit_o  (hit[k])
    );
  end

  assign idx_inc   = idx_q + idx_t'(1);
  assign diff      = idx_inc - idx_t'(pat_len_q);
  assign pat_ok    = pat_closed_q && !pat_long_q && (pat_len_q != '0);
  assign win_eq    = &(hit | ~care);
  assign match     = pat_ok && win_eq && (idx_inc >= idx_t'(pat_len_q))
                     && (diff >= idx_t'(start_q));
  assign seen_now  = seen_q || (txt_live && match);
  assign first_now = seen_q ? first_q : diff[PosW-1:0];

  always_comb begin
    pat_len_d    = pat_len_q;
    pat_closed_d = pat_closed_q;
    pat_long_d   = pat_long_q;
    idx_d        = idx_q;
    seen_d       = seen_q;
    first_d      = first_q;
    txt_long_d   = txt_long_q;
    if (pat_fire) begin
      pat_closed_d = in_i.last;
      pat_long_d   = pat_closed_q ? 1'b0 : pat_long_q;
      if (ctrl.pat_shift) begin
        pat_len_d = pat_base + len_t'(1);
      end else begin
        pat_len_d  = pat_base;
        pat_long_d = 1'b1;
      end
    end
    if (txt_fire) begin
      if (txt_live) begin
        idx_d   = idx_inc;
        seen_d  = seen_now;
        first_d = seen_now ? first_now : first_q;
      end else begin
        txt_long_d = 1'b1;
      end
      if (in_i.last) begin
        idx_d      = '0;
        seen_d     = 1'b0;
        first_d    = '0;
        txt_long_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q      <= '0;
      pat_len_q    <= '0;
      pat_closed_q <= 1'b1;
      pat_long_q   <= 1'b0;
      idx_q        <= '0;
      seen_q       <= 1'b0;
      first_q      <= '0;
      txt_long_q   <= 1'b0;
      ovalid_q     <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        start_q <= cfg_i.start_pos;
      end
      pat_len_q    <= pat_len_d;
      pat_closed_q <= pat_closed_d;
      pat_long_q   <= pat_long_d;
      idx_q        <= idx_d;
      seen_q       <= seen_d;
      first_q      <= first_d;
      txt_long_q   <= txt_long_d;
      if (txt_fire && in_i.last) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (txt_fire && in_i.last) begin
      found_q <= seen_now;
      mpos_q  <= seen_now ? first_now : '0;
      povf_q  <= pat_long_q || (pat_len_q == '0);
      tovf_q  <= txt_long_q || !txt_live;
    end
  end

  assign out_o.valid            = ovalid_q;
  assign out_o.found            = found_q;
  assign out_o.match_pos        = mpos_q;
  assign out_o.pattern_overflow = povf_q;
  assign out_o.text_overflow    = tovf_q;

endmodule

`default_nettype wire

// File: rtl/sfms_chk.sv
`default_nettype none
`include "substring_first_match_search_macros.svh"

module sfms_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        in_req_type_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        out_found_i,
  input  logic [11:0] out_match_pos_i,
  input  logic [11:0] out_payload_pos_i
);
  import sfms_pkg::*;

  logic last_text_fire;
  assign last_text_fire = in_valid_i && in_ready_i && (in_req_type_i == ReqText) && in_last_i;

  // a held result stays valid and keeps its match position
  `SFMS_ASSERT_NXT(a_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_payload_pos_i), "result dropped or changed while stalled")
  // every last text char yields a result in the next cycle
  `SFMS_ASSERT_NXT(a_result, last_text_fire, out_valid_i, "no result after last text char")
  // no match means position zero
  `SFMS_ASSERT_IMP(a_pos_zero, out_valid_i && !out_found_i, out_match_pos_i == 12'd0, "match_pos set without a match")
  // input stalls only behind a waiting result
  `SFMS_ASSERT_IMP(a_stall, !in_ready_i, out_valid_i && !out_ready_i, "input stalled with no result waiting")

endmodule

bind substring_first_match_search sfms_chk u_sfms_chk (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .in_valid_i             (in_i.valid),
  .in_ready_i             (in_i.ready),
  .in_req_type_i          (in_i.req_type),
  .in_last_i              (in_i.last),
  .out_valid_i            (out_o.valid),
  .out_ready_i            (out_o.ready),
  .out_found_i            (out_o.found),
  .out_match_pos_i        (out_o.match_pos),
  .out_payload_pos_i      (out_o.match_pos)
);

`default_nettype wire

// File: verif/substring_first_match_search_tb.sv
`timescale 1ns / 100ps

module substring_first_match_search_tb;
  import sfms_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;

  typedef struct packed {
    logic found;
    pos_t match_pos;
    logic pattern_overflow;
    logic text_overflow;
  } search_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  sfms_in_if  in_if();
  sfms_out_if out_if();
  sfms_cfg_if cfg_if();

  substring_first_match_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // search state as the block should hold it
  char_t       pat_mem [MaxPatLen];
  int unsigned pat_len;
  bit          pat_closed;
  bit          pat_long;
  char_t       win [MaxPatLen];
  int unsigned txt_idx;
  bit          hit_seen;
  pos_t        hit_pos;
  bit          txt_long;
  pos_t        start_pos_m;

  search_result_t pending_results[$];
  search_result_t got_r, want_r;
  char_t          letters[3];
  int unsigned    idle_pct;
  int unsigned    stall_pct;
  int unsigned    items_sent;
  int unsigned    errors;
  int unsigned    cycles;

  function automatic void clear_text();
    for (int k = 0; k < MaxPatLen; k++) win[k] = '0;
    txt_idx  = 0;
    hit_seen = 1'b0;
    hit_pos  = '0;
    txt_long = 1'b0;
  endfunction

  function automatic bit window_hit();
    int unsigned n;
    n = pat_len;
    if (!pat_closed || pat_long || n == 0 || n > MaxPatLen) return 1'b0;
    if (txt_idx + 1 < n) return 1'b0;
    if (txt_idx + 1 - n < start_pos_m) return 1'b0;
    for (int j = 0; j < n; j++) begin
      if (pat_mem[j] != win[n - 1 - j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void advance_search(logic rt, char_t c, logic lst);
    search_result_t r;
    if (rt == ReqPattern) begin
      if (pat_closed) begin
        pat_len    = 0;
        pat_long   = 1'b0;
        pat_closed = 1'b0;
      end
      if (pat_len < MaxPatLen) begin
        pat_mem[pat_len] = c;
        pat_len++;
      end else begin
        pat_long = 1'b1;
      end
      if (lst) pat_closed = 1'b1;
    end else begin
      if (txt_idx >= MaxTextLen) begin
        txt_idx  = MaxTextLen;
        txt_long = 1'b1;
      end else begin
        for (int k = MaxPatLen - 1; k > 0; k--) win[k] = win[k - 1];
        win[0] = c;
        if (!hit_seen && window_hit()) begin
          hit_seen = 1'b1;
          hit_pos  = pos_t'(txt_idx + 1 - pat_len);
        end
        txt_idx++;
      end
      if (lst) begin
        r.found            = hit_seen;
        r.match_pos        = hit_seen ? hit_pos : pos_t'(0);
        r.pattern_overflow = pat_long || (pat_len == 0);
        r.text_overflow    = txt_long;
        pending_results.push_back(r);
        clear_text();
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // receiver side
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing pending");
      end else begin
        want_r = pending_results.pop_front();
        got_r.found            = out_if.found;
        got_r.match_pos        = out_if.match_pos;
        got_r.pattern_overflow = out_if.pattern_overflow;
        got_r.text_overflow    = out_if.text_overflow;
        if (got_r.found !== want_r.found)
          report_mismatch($sformatf("found %b, want %b", got_r.found, want_r.found));
        if (got_r.match_pos !== want_r.match_pos)
          report_mismatch($sformatf("match_pos %0d, want %0d",
                                    got_r.match_pos, want_r.match_pos));
        if (got_r.pattern_overflow !== want_r.pattern_overflow)
          report_mismatch($sformatf("pattern_overflow %b, want %b",
                                    got_r.pattern_overflow, want_r.pattern_overflow));
        if (got_r.text_overflow !== want_r.text_overflow)
          report_mismatch($sformatf("text_overflow %b, want %b",
                                    got_r.text_overflow, want_r.text_overflow));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_char(logic rt, char_t c, logic lst);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.req_type <= rt;
    in_if.ch       <= c;
    in_if.last     <= lst;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    advance_search(rt, c, lst);
    items_sent++;
  endtask

  task automatic send_seq(logic rt, char_t chars[$], logic closing);
    for (int i = 0; i < chars.size(); i++)
      send_char(rt, chars[i], closing && (i == chars.size() - 1));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_start_pos(pos_t v);
    wait_idle();
    @(negedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.start_pos <= v;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    start_pos_m = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_directed();
    char_t s[$];
    idle_pct  = 0;
    stall_pct = 0;
    // empty pattern right after reset
    send_char(ReqText, 8'h41, 1'b1);
    send_char(ReqPattern, 8'h01, 1'b1);
    send_char(ReqText, 8'h01, 1'b1);
    s = '{8'hFF, 8'h80};
    send_seq(ReqPattern, s, 1'b1);
    s = '{8'h7F, 8'hFF, 8'h80, 8'hFF, 8'h80};
    send_seq(ReqText, s, 1'b1);
    // pattern still open while text streams
    send_char(ReqPattern, 8'h55, 1'b0);
    send_char(ReqText, 8'h55, 1'b1);
    send_char(ReqPattern, 8'hAA, 1'b1);
    s = '{8'h55, 8'hAA};
    send_seq(ReqText, s, 1'b0);
    // new pattern in the middle of a text, earlier hit kept
    send_char(ReqPattern, 8'h2A, 1'b1);
    s = '{8'h2A, 8'h01, 8'h2A};
    send_seq(ReqText, s, 1'b1);
    // pattern longer than text
    s = '{8'h10, 8'h20, 8'h40};
    send_seq(ReqPattern, s, 1'b1);
    s = '{8'h10, 8'h20};
    send_seq(ReqText, s, 1'b1);
    // start position against hits
    write_start_pos(12'd3);
    s = '{8'h10, 8'h20, 8'h40, 8'h10, 8'h20, 8'h40};
    send_seq(ReqText, s, 1'b1);
    write_start_pos(12'd4);
    send_seq(ReqText, s, 1'b1);
    write_start_pos(12'd0);
  endtask

  task automatic test_long_pattern();
    char_t p[$];
    char_t t[$];
    idle_pct  = 0;
    stall_pct = 0;
    for (int i = 0; i < MaxPatLen; i++) p.push_back(char_t'($urandom_range(1, 255)));
    send_seq(ReqPattern, p, 1'b1);
    t = p;
    t.push_front(8'h01);
    send_seq(ReqText, t, 1'b1);
    p.push_back(8'h99);
    p.push_back(8'h66);
    send_seq(ReqPattern, p, 1'b1);
    send_seq(ReqText, t, 1'b1);
    wait_idle();
  endtask

  task automatic test_long_text();
    char_t p[$];
    char_t t[$];
    idle_pct  = 0;
    stall_pct = 0;
    // full length text, full length pattern right at the end
    write_start_pos(12'd0);
    for (int i = 0; i < MaxPatLen; i++) p.push_back(char_t'($urandom_range(128, 255)));
    send_seq(ReqPattern, p, 1'b1);
    for (int i = 0; i < MaxTextLen - MaxPatLen; i++) t.push_back(char_t'($urandom_range(1, 127)));
    for (int i = 0; i < MaxPatLen; i++) t.push_back(p[i]);
    send_seq(ReqText, t, 1'b1);
    // hit at the last index, then text beyond the limit
    write_start_pos(12'hFFF);
    send_char(ReqPattern, 8'hC3, 1'b1);
    t.delete();
    for (int i = 0; i < MaxTextLen - 1; i++) t.push_back(char_t'($urandom_range(1, 127)));
    t.push_back(8'hC3);
    for (int i = 0; i < 3; i++) t.push_back(char_t'($urandom_range(1, 255)));
    send_seq(ReqText, t, 1'b1);
    write_start_pos(12'd0);
  endtask

  task automatic test_random(int unsigned n, int unsigned send_idle, int unsigned recv_stall);
    int unsigned target;
    int unsigned kind;
    int unsigned plen;
    int unsigned off;
    int unsigned h;
    int unsigned r;
    bit          wide;
    char_t       p[$];
    char_t       t[$];
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    target    = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(11) == 0) begin
        r = $urandom_range(9);
        case (r)
          0:       write_start_pos(pos_t'(0));
          1:       write_start_pos(pos_t'(12'hFFF));
          8, 9:    write_start_pos(pos_t'($urandom_range(0, 4095)));
          default: write_start_pos(pos_t'($urandom_range(0, 6)));
        endcase
      end
      kind = $urandom_range(99);
      wide = ($urandom_range(4) == 0);
      for (int i = 0; i < 3; i++) letters[i] = char_t'($urandom_range(1, 255));
      r = $urandom_range(99);
      if (r < 85) plen = $urandom_range(1, 4);
      else if (r < 97) plen = $urandom_range(5, MaxPatLen);
      else plen = $urandom_range(MaxPatLen + 1, MaxPatLen + 4);
      p.delete();
      for (int i = 0; i < plen; i++)
        p.push_back(wide ? char_t'($urandom_range(1, 255)) : letters[$urandom_range(2)]);
      t.delete();
      r = $urandom_range(24);
      for (int i = 0; i < r; i++)
        t.push_back(wide ? char_t'($urandom_range(1, 255)) : letters[$urandom_range(2)]);
      if ($urandom_range(9) < 6) begin
        off = $urandom_range(0, t.size());
        for (int i = 0; i < p.size() && i < MaxPatLen; i++) t.insert(off + i, p[i]);
      end
      if (t.size() == 0) t.push_back(letters[0]);
      if (kind < 70) begin
        send_seq(ReqPattern, p, 1'b1);
        send_seq(ReqText, t, 1'b1);
      end else if (kind < 82) begin
        send_seq(ReqText, t, 1'b1);
      end else if (kind < 92) begin
        h = $urandom_range(0, t.size() - 1);
        for (int i = 0; i < h; i++) send_char(ReqText, t[i], 1'b0);
        send_seq(ReqPattern, p, 1'b1);
        for (int i = h; i < t.size(); i++) send_char(ReqText, t[i], i == t.size() - 1);
      end else begin
        send_seq(ReqPattern, p, 1'b0);
        send_seq(ReqText, t, 1'b1);
        send_char(ReqPattern, letters[$urandom_range(2)], 1'b1);
      end
    end
    wait_idle();
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.req_type   = ReqPattern;
    in_if.ch         = '0;
    in_if.last       = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.start_pos = '0;
    out_if.ready     = 1'b0;
    idle_pct         = 0;
    stall_pct        = 0;
    items_sent       = 0;
    errors           = 0;
    cycles           = 0;
    start_pos_m      = '0;
    pat_len          = 0;
    pat_closed       = 1'b1;
    pat_long         = 1'b0;
    for (int k = 0; k < MaxPatLen; k++) pat_mem[k] = '0;
    clear_text();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_long_pattern();
    test_long_text();
    test_random(350, 0, 0);
    test_random(350, 86, 0);
    test_random(350, 0, 86);
    test_random(350, 17, 17);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
